FILE: rtl/deq_pkg.sv
// Shared types and constants for the circular deque block.
// Holds request codes, status codes, FSM states and the result record.
// No dependencies; imported by deq_ctrl, deq_out and circular_deque.
`timescale 1ns / 1ps

package deq_pkg;

    // Default ring capacity in words
    localparam int CAPACITY_DEF = 16;

    // Field widths
    localparam int DATA_W    = 32;
    localparam int MODE_W    = 3;
    localparam int STATUS_W  = 2;
    localparam int OCC_W     = 5;
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 2;

    // Request codes
    localparam logic [MODE_W-1:0] MODE_INS_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INS_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DEL_FRONT = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DEL_BACK  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DUMP      = 3'd4;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Controller states
    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    // One result record handed to the output stage
    typedef struct packed {
        logic [DATA_W-1:0] value;
        status_t           status;
        logic              last;
        logic [OCC_W-1:0]  occupancy;
    } result_t;

endpackage

FILE: rtl/deq_ram.sv
// Ring store of the deque: one write port, one read port.
// Read data is registered and holds until the next read; no reset on contents.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module deq_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 32
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/deq_ctrl.sv
// Deque controller: front pointer, word count and the request sequencer.
// Drives the ring store ports and hands result records to the output stage.
// Depends on deq_pkg.
`timescale 1ns / 1ps

module deq_ctrl #(
    parameter  int CAPACITY = deq_pkg::CAPACITY_DEF,
    localparam int IW       = $clog2(CAPACITY),
    localparam int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  logic [deq_pkg::MODE_W-1:0]   req_mode,
    input  logic [deq_pkg::DATA_W-1:0]   req_value,
    output logic                         ram_wr_en,
    output logic [IW-1:0]                ram_wr_addr,
    output logic [deq_pkg::DATA_W-1:0]   ram_wr_data,
    output logic                         ram_rd_en,
    output logic [IW-1:0]                ram_rd_addr,
    input  logic [deq_pkg::DATA_W-1:0]   ram_rd_data,
    input  logic                         res_free,
    output logic                         res_push,
    output deq_pkg::result_t             res
);

    import deq_pkg::*;

    state_t              state_reg, state_next;
    logic [IW-1:0]       front_reg, front_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [DATA_W-1:0]   value_reg, value_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic                full;
    logic                empty;
    logic                dump_last;
    logic [IW-1:0]       front_dec;

    // Ring position base + off, both below CAPACITY
    function automatic logic [IW-1:0] ring_add(logic [IW-1:0] base, logic [CW-1:0] off);
        logic [IW:0] sum;
        sum = {1'b0, base} + (IW + 1)'(off);
        if (sum >= (IW + 1)'(CAPACITY)) begin
            sum = sum - (IW + 1)'(CAPACITY);
        end
        return sum[IW-1:0];
    endfunction

    assign full      = (count_reg == CW'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign dump_last = ((CW'(idx_reg) + CW'(1)) == count_reg);
    assign front_dec = (front_reg == '0) ? IW'(CAPACITY - 1) : front_reg - IW'(1);

    // State and pointer registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            front_reg <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    // Request payload and dump offset
    always_ff @(posedge aclk) begin
        mode_reg  <= mode_next;
        value_reg <= value_next;
        idx_reg   <= idx_next;
    end

    // Sequence one request; reads are issued and registered ahead of their use,
    // and writes occur only in the execute step, so no access to one entry overlaps
    always_comb begin
        state_next    = state_reg;
        front_next    = front_reg;
        count_next    = count_reg;
        mode_next     = mode_reg;
        value_next    = value_reg;
        idx_next      = idx_reg;
        req_ready     = 1'b0;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = ring_add(front_reg, count_reg);
        ram_wr_data   = value_reg;
        ram_rd_en     = 1'b0;
        ram_rd_addr   = front_reg;
        res_push      = 1'b0;
        res.value     = '0;
        res.status    = ST_OK;
        res.last      = 1'b1;
        res.occupancy = OCC_W'(count_reg);

        case (state_reg)
            S_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    mode_next  = req_mode;
                    value_next = req_value;
                    idx_next   = '0;
                    // drop unknown codes without a result
                    if (req_mode <= MODE_DUMP) begin
                        state_next = S_EXEC;
                    end
                    // fetch the word a delete or dump will need
                    ram_rd_en = (req_mode inside {MODE_DEL_FRONT, MODE_DEL_BACK, MODE_DUMP})
                                && !empty;
                    if (req_mode == MODE_DEL_BACK) begin
                        ram_rd_addr = ring_add(front_reg, count_reg - CW'(1));
                    end
                end
            end

            S_EXEC: begin
                case (mode_reg)
                    MODE_INS_FRONT, MODE_INS_BACK: begin
                        res_push = res_free;
                        if (full) begin
                            res.status = ST_FULL;
                        end else begin
                            res.occupancy = OCC_W'(count_reg + CW'(1));
                            if (res_free) begin
                                ram_wr_en  = 1'b1;
                                count_next = count_reg + CW'(1);
                                if (mode_reg == MODE_INS_FRONT) begin
                                    ram_wr_addr = front_dec;
                                    front_next  = front_dec;
                                end
                            end
                        end
                        if (res_free) begin
                            state_next = S_IDLE;
                        end
                    end

                    MODE_DEL_FRONT, MODE_DEL_BACK: begin
                        res_push = res_free;
                        if (empty) begin
                            res.status = ST_EMPTY;
                        end else begin
                            res.value     = ram_rd_data;
                            res.occupancy = OCC_W'(count_reg - CW'(1));
                            if (res_free) begin
                                count_next = count_reg - CW'(1);
                                if (mode_reg == MODE_DEL_FRONT) begin
                                    front_next = ring_add(front_reg, CW'(1));
                                end
                            end
                        end
                        if (res_free) begin
                            state_next = S_IDLE;
                        end
                    end

                    MODE_DUMP: begin
                        res_push = res_free;
                        if (empty) begin
                            res.status = ST_EMPTY;
                            if (res_free) begin
                                state_next = S_IDLE;
                            end
                        end else begin
                            res.value = ram_rd_data;
                            res.last  = dump_last;
                            if (res_free) begin
                                if (dump_last) begin
                                    state_next = S_IDLE;
                                end else begin
                                    // advance to the next word while this one leaves
                                    ram_rd_en   = 1'b1;
                                    ram_rd_addr = ring_add(front_reg,
                                                           CW'(idx_reg) + CW'(1));
                                    idx_next    = idx_reg + IW'(1);
                                end
                            end
                        end
                    end

                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Count never passes the ring size
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("deque count above capacity");

    // Store is never read and written in one cycle
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_wr_en && ram_rd_en))
        else $error("ring store read and write overlap");

    // A stored insert grows the count by one
    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_wr_en && res_push) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not advance count");

    // A successful front delete moves the front pointer
    a_del_front: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXEC && mode_reg == MODE_DEL_FRONT && res_push && !empty)
        |=> (front_reg == ring_add($past(front_reg), CW'(1))))
        else $error("front delete did not move front pointer");

endmodule

FILE: rtl/deq_out.sv
// Output register stage for deque results onto the master stream side.
// Holds one result until taken and reports when a new one may be loaded.
// Depends on deq_pkg.
`timescale 1ns / 1ps

module deq_out (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           res_push,
    input  deq_pkg::result_t               res,
    output logic                           res_free,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [deq_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [deq_pkg::M_TUSER_W-1:0]  m_tuser,
    output logic                           m_tlast
);

    import deq_pkg::*;

    logic    m_tvalid_reg;
    result_t res_reg;

    assign res_free = !m_tvalid_reg || m_tready;

    // Valid flag: set on load, clear when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_push) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Payload: load only into a free slot
    always_ff @(posedge aclk) begin
        if (res_push && res_free) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(M_TDATA_W - DATA_W - OCC_W)'(0), res_reg.occupancy, res_reg.value};
    assign m_tuser  = res_reg.status;
    assign m_tlast  = res_reg.last;

    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        res_push |-> res_free)
        else $error("result pushed into a full output stage");

    // A result that was not taken stays in place
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result changed");

endmodule

FILE: rtl/circular_deque.sv
// Bounded double-ended queue of signed 32-bit words kept in a ring store.
// Insert/delete: taken in the accept step, result formed in the execute step and then
// registered in the output stage; the next request is taken once that result is handed on;
// a dump streams one word per cycle after the first read while the output is not stalled.
// Reset: front pointer and count clear at once; store contents stay undefined, no sweep.
// Depends on deq_pkg, deq_ram, deq_ctrl and deq_out.
`timescale 1ns / 1ps

module circular_deque #(
    parameter int CAPACITY = deq_pkg::CAPACITY_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [deq_pkg::S_TDATA_W-1:0]  s_tdata,   // [31:0] item_value
    input  logic [deq_pkg::S_TUSER_W-1:0]  s_tuser,   // [2:0] mode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [deq_pkg::M_TDATA_W-1:0]  m_tdata,   // [31:0] out_value, [36:32] occupancy
    output logic [deq_pkg::M_TUSER_W-1:0]  m_tuser,   // [1:0] status
    output logic                           m_tlast    // last_flag
);

    import deq_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);

    logic              ram_wr_en;
    logic [IDX_W-1:0]  ram_wr_addr;
    logic [DATA_W-1:0] ram_wr_data;
    logic              ram_rd_en;
    logic [IDX_W-1:0]  ram_rd_addr;
    logic [DATA_W-1:0] ram_rd_data;
    logic              res_free;
    logic              res_push;
    result_t           res;

    // Ring store
    deq_ram #(
        .DEPTH  (CAPACITY),
        .ADDR_W (IDX_W),
        .DATA_W (DATA_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Request sequencer and pointers
    deq_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req_valid   (s_tvalid),
        .req_ready   (s_tready),
        .req_mode    (s_tuser),
        .req_value   (s_tdata),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .res_free    (res_free),
        .res_push    (res_push),
        .res         (res)
    );

    // Result register
    deq_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res_push (res_push),
        .res      (res),
        .res_free (res_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
